/* design/i2cm_pkg.sv */
package i2cm_pkg;

	// Command codes carried in req_type
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STOP  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// Bits per byte on the bus
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Half period timer value after reset
	localparam logic [15:0] HALF_TICKS_RESET = 16'd10;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] req_type;
		logic [7:0] wr_data;
		logic       send_ack;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rd_data;
		logic       ack_received;
	} rsp_t;

endpackage

/* design/i2c_master_byte_engine_top.sv */
// A transaction goes from the input register to the result register, waiting in the input
// register while rsp_stall holds a full result register. Throughput: one transaction per cycle
// when not stalled; the engine state advances one tick per transaction in one registered update.
// Reset (arst_n low, asynchronous): pipeline empty, engine idle, lines released high,
// acknowledge bit high, half period register back to 10 ticks.
module i2c_master_byte_engine_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  i2cm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output i2cm_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata
);

	logic           vld_s1;
	i2cm_pkg::req_t req_s1;
	logic           adv;
	logic [15:0]    half_ticks_q;
	i2cm_pkg::rsp_t step_rsp;
	logic           rsp_vld_q;
	i2cm_pkg::rsp_t rsp_q;

	// Advance when an item waits and the result register is free
	assign adv       = vld_s1 && (!rsp_vld_q || !rsp_stall);
	assign req_stall = vld_s1 && !adv;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// Half period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ticks_q <= i2cm_pkg::HALF_TICKS_RESET;
		end else if (cfg_we) begin
			half_ticks_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!req_stall) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	i2cm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.half_ticks (half_ticks_q),
		.req        (req_s1),
		.rsp        (step_rsp)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= step_rsp;
		end
	end

	// A completed command never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_q.done_res |-> !rsp_q.busy_res)
		else $error("done reported while busy");

	// Input stalls only behind a waiting item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> vld_s1)
		else $error("input stalled with empty input register");

	// Every step lands in the result register
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_vld_q)
		else $error("engine step lost its result");

endmodule

/* design/i2cm_engine.sv */
module i2cm_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [15:0]          half_ticks,
	input  i2cm_pkg::req_t       req,
	output i2cm_pkg::rsp_t       rsp
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_START_A = 4'd1,
		PH_START_B = 4'd2,
		PH_STOP_A  = 4'd3,
		PH_STOP_B  = 4'd4,
		PH_W_HIGH  = 4'd5,
		PH_W_LOW   = 4'd6,
		PH_W_ACK   = 4'd7,
		PH_R_HIGH  = 4'd8,
		PH_R_LOW   = 4'd9,
		PH_R_ACK   = 4'd10
	} phase_t;

	phase_t      phase_q, phase_n;
	logic        busy_q, busy_n;
	logic [3:0]  bit_idx_q, bit_idx_n;
	logic [15:0] timer_q, timer_n;
	logic [7:0]  shift_q, shift_n;
	logic [7:0]  rd_byte_q, rd_byte_n;
	logic        ack_q, ack_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        ack_send_q, ack_send_n;
	logic        done_n;
	logic [15:0] hold_ticks;
	logic [3:0]  bit_idx_inc;

	// A zero period acts as one tick
	assign hold_ticks  = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
	assign bit_idx_inc = bit_idx_q + 4'd1;

	// Work out the next state for one tick
	always_comb begin
		phase_n    = phase_q;
		busy_n     = busy_q;
		bit_idx_n  = bit_idx_q;
		timer_n    = timer_q;
		shift_n    = shift_q;
		rd_byte_n  = rd_byte_q;
		ack_n      = ack_q;
		scl_n      = scl_q;
		sda_n      = sda_q;
		ack_send_n = ack_send_q;
		done_n     = 1'b0;

		if (!busy_q) begin
			if (req.cmd_valid) begin
				busy_n    = 1'b1;
				bit_idx_n = 4'd0;
				timer_n   = hold_ticks;
				scl_n     = 1'b1;
				case (req.req_type)
					i2cm_pkg::REQ_START: begin
						phase_n = PH_START_A;
						sda_n   = 1'b1;
					end
					i2cm_pkg::REQ_STOP: begin
						phase_n = PH_STOP_A;
						sda_n   = 1'b0;
					end
					i2cm_pkg::REQ_WRITE: begin
						phase_n = PH_W_HIGH;
						sda_n   = req.wr_data[7];
						shift_n = {req.wr_data[6:0], 1'b0};
					end
					default: begin
						phase_n    = PH_R_HIGH;
						sda_n      = 1'b1;
						shift_n    = 8'd0;
						ack_send_n = req.send_ack;
					end
				endcase
			end
		end else if (timer_q > 16'd1) begin
			timer_n = timer_q - 16'd1;
		end else begin
			timer_n = hold_ticks;
			case (phase_q)
				PH_START_A: begin
					phase_n = PH_START_B;
					scl_n   = 1'b1;
					sda_n   = 1'b0;
				end
				PH_START_B: begin
					scl_n   = 1'b0;
					phase_n = PH_IDLE;
					busy_n  = 1'b0;
					timer_n = 16'd0;
					done_n  = 1'b1;
				end
				PH_STOP_A: begin
					phase_n = PH_STOP_B;
					scl_n   = 1'b1;
					sda_n   = 1'b1;
				end
				PH_STOP_B: begin
					phase_n = PH_IDLE;
					busy_n  = 1'b0;
					timer_n = 16'd0;
					done_n  = 1'b1;
				end
				PH_W_HIGH: begin
					phase_n = PH_W_LOW;
					scl_n   = 1'b0;
				end
				PH_W_LOW: begin
					bit_idx_n = bit_idx_inc;
					scl_n     = 1'b1;
					if (bit_idx_inc >= i2cm_pkg::BITS_PER_BYTE) begin
						phase_n = PH_W_ACK;
						sda_n   = 1'b1;
					end else begin
						// shift out the next bit, MSB first
						phase_n = PH_W_HIGH;
						sda_n   = shift_q[7];
						shift_n = {shift_q[6:0], 1'b0};
					end
				end
				PH_W_ACK: begin
					ack_n   = req.sda_in;
					scl_n   = 1'b0;
					phase_n = PH_IDLE;
					busy_n  = 1'b0;
					timer_n = 16'd0;
					done_n  = 1'b1;
				end
				PH_R_HIGH: begin
					shift_n = {shift_q[6:0], req.sda_in};
					phase_n = PH_R_LOW;
					scl_n   = 1'b0;
					sda_n   = 1'b1;
				end
				PH_R_LOW: begin
					bit_idx_n = bit_idx_inc;
					scl_n     = 1'b1;
					if (bit_idx_inc >= i2cm_pkg::BITS_PER_BYTE) begin
						phase_n = PH_R_ACK;
						sda_n   = ~ack_send_q;
					end else begin
						phase_n = PH_R_HIGH;
						sda_n   = 1'b1;
					end
				end
				PH_R_ACK: begin
					rd_byte_n = shift_q;
					scl_n     = 1'b0;
					phase_n   = PH_IDLE;
					busy_n    = 1'b0;
					timer_n   = 16'd0;
					done_n    = 1'b1;
				end
				default: begin
					// idle or unknown phase while busy: drop back to idle
					phase_n = PH_IDLE;
					busy_n  = 1'b0;
					timer_n = 16'd0;
				end
			endcase
		end
	end

	// Result reflects the state after this tick
	always_comb begin
		rsp.scl_out      = scl_n;
		rsp.sda_out      = sda_n;
		rsp.busy_res     = busy_n;
		rsp.done_res     = done_n;
		rsp.rd_data      = rd_byte_n;
		rsp.ack_received = ack_n;
	end

	// Hold engine state, advance one tick per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			busy_q     <= 1'b0;
			bit_idx_q  <= 4'd0;
			timer_q    <= 16'd0;
			shift_q    <= 8'd0;
			rd_byte_q  <= 8'd0;
			ack_q      <= 1'b1;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_send_q <= 1'b0;
		end else if (en) begin
			phase_q    <= phase_n;
			busy_q     <= busy_n;
			bit_idx_q  <= bit_idx_n;
			timer_q    <= timer_n;
			shift_q    <= shift_n;
			rd_byte_q  <= rd_byte_n;
			ack_q      <= ack_n;
			scl_q      <= scl_n;
			sda_q      <= sda_n;
			ack_send_q <= ack_send_n;
		end
	end

endmodule
